// File: rtl/lia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Listener identifier allocator package
// Shared constants, status codes and types of the identifier allocator.
// ----------------------------------------------------------------------------
package lia_pkg;

    localparam int ID_COUNT = 256;
    localparam int ID_W     = 9;
    localparam int ADDR_W   = $clog2(ID_COUNT);
    localparam int CNT_W    = $clog2(ID_COUNT + 1);

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;
    typedef logic [1:0]        status_t;

    localparam status_t STATUS_OK          = 2'd0;
    localparam status_t STATUS_NOT_IN_USE  = 2'd1;
    localparam status_t STATUS_EXHAUSTED   = 2'd2;

    localparam logic ACTION_ALLOCATE = 1'b0;
    localparam logic ACTION_RELEASE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage : lia_pkg
`default_nettype wire

// File: rtl/lia_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Recycle FIFO
// Memory of released identifiers with head, tail and fill count; the head
// entry is read into an output register when rd_en is set.
// ----------------------------------------------------------------------------
module lia_fifo
    import lia_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic rd_en,
    input  wire logic pop,
    input  wire logic push,
    input  wire id_t  push_id,
    output id_t       rd_data,
    output logic      not_empty
);

    localparam addr_t LAST_ADDR = ADDR_W'(ID_COUNT - 1);

    id_t    mem [ID_COUNT];
    id_t    rd_data_reg;
    addr_t  head_reg, head_next;
    addr_t  tail_reg, tail_next;
    count_t count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == LAST_ADDR) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_id;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data   = rd_data_reg;
    assign not_empty = (count_reg != '0);

endmodule : lia_fifo
`default_nettype wire

// File: rtl/lia_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// In-use map
// One bit per identifier in a memory with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module lia_map
    import lia_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rd_en,
    input  wire addr_t rd_addr,
    input  wire logic  wr_en,
    input  wire addr_t wr_addr,
    input  wire logic  wr_data,
    output logic       rd_data
);

    logic mem [ID_COUNT];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : lia_map
`default_nettype wire

// File: rtl/listener_id_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Listener identifier allocator
// Hands out identifiers from 1 to 256, recycling released ones oldest first.
// ----------------------------------------------------------------------------
// At acceptance the recycle FIFO head and the in-use bit of the given
// identifier are read from their memories; in the execute state the result is
// formed, both memories are written back and the response is placed in the
// output register. A response that is not taken holds the execute state, and
// a new transfer is accepted only in the idle state. Identifiers at or above
// the fresh counter have never been handed out and read as not in use, so no
// clearing pass is needed after reset. Once all 256 fresh identifiers are used
// and the FIFO is empty, an allocation answers with the exhausted status.
// ----------------------------------------------------------------------------
module listener_id_allocator
    import lia_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // action [0], release_id [9:1], zeros
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // granted_id [8:0], status [10:9], zeros
);

    state_t  state_reg, state_next;
    logic    action_reg;
    id_t     rid_reg;
    id_t     fresh_reg, fresh_next;
    logic    m_tvalid_reg, m_tvalid_next;
    id_t     granted_reg, granted_next;
    status_t status_reg, status_next;

    logic    accept;
    logic    finish;
    id_t     in_rid;
    logic    fifo_pop, fifo_push, fifo_not_empty;
    id_t     fifo_rd_data;
    logic    map_wr_en, map_wr_data, map_rd_data;
    addr_t   map_wr_addr;
    logic    rid_in_use;

    assign in_rid   = s_tdata[9:1];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    assign rid_in_use = (rid_reg != '0) && (rid_reg < fresh_reg) && map_rd_data;

    always_comb
    begin
        fresh_next    = fresh_reg;
        granted_next  = granted_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        fifo_pop      = 1'b0;
        fifo_push     = 1'b0;
        map_wr_en     = 1'b0;
        map_wr_addr   = ADDR_W'(rid_reg - 1'b1);
        map_wr_data   = 1'b0;
        if (finish)
        begin
            m_tvalid_next = 1'b1;
            granted_next  = '0;
            status_next   = STATUS_OK;
            if (action_reg == ACTION_ALLOCATE)
            begin
                if (fifo_not_empty)
                begin
                    granted_next = fifo_rd_data;
                    fifo_pop     = 1'b1;
                    map_wr_en    = 1'b1;
                end
                else if (fresh_reg <= ID_W'(ID_COUNT))
                begin
                    granted_next = fresh_reg;
                    fresh_next   = fresh_reg + 1'b1;
                    map_wr_en    = 1'b1;
                end
                else
                begin
                    status_next = STATUS_EXHAUSTED;
                end
                map_wr_addr = ADDR_W'(granted_next - 1'b1);
                map_wr_data = 1'b1;
            end
            else if (rid_in_use)
            begin
                map_wr_en = 1'b1;
                fifo_push = 1'b1;
            end
            else
            begin
                status_next = STATUS_NOT_IN_USE;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fresh_reg    <= ID_W'(1);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fresh_reg    <= fresh_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= s_tdata[0];
            rid_reg    <= in_rid;
        end
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    lia_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .pop       (fifo_pop),
        .push      (fifo_push),
        .push_id   (rid_reg),
        .rd_data   (fifo_rd_data),
        .not_empty (fifo_not_empty)
    );

    lia_map u_map (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(in_rid - 1'b1)),
        .wr_en   (map_wr_en),
        .wr_addr (map_wr_addr),
        .wr_data (map_wr_data),
        .rd_data (map_rd_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, status_reg, granted_reg};

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("Accepted transfer did not enter the execute state.");

    a_finish_gives_response: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> m_tvalid_reg)
        else $error("Completed transfer produced no response.");

    a_fresh_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg != $past(fresh_reg)) |-> (fresh_reg == $past(fresh_reg) + 1'b1))
        else $error("Fresh counter moved by other than one.");

endmodule : listener_id_allocator
`default_nettype wire

// File: verif/listener_id_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Listener identifier allocator testbench
// A short directed table exercises the fresh counter, recycling of released
// identifiers oldest first, rejected releases and ignored fields. Then phases
// of random requests, weighted towards allocation or release, run the
// allocator into exhaustion again and again. Every response transfer is
// compared with the fixed values of the table or with a predictor of the
// allocator while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module listener_id_allocator_tb;
    import lia_pkg::*;

    localparam int          RANDOM_ITEMS = 1700;
    localparam int          PHASE_LEN    = 150;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_START   = 1500;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam logic        FIXED        = 1'b1;
    localparam logic        PREDICTED    = 1'b0;

    typedef struct packed {
        logic    action;
        id_t     release_id;
        logic    source;
        id_t     granted_id;
        status_t status;
    } stim_row_t;

    typedef struct {
        id_t     granted_id;
        status_t status;
    } reply_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    localparam stim_row_t DIRECTED_ROWS [22] = '{
        '{ACTION_ALLOCATE, 9'd0,   FIXED,     9'd1, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd511, FIXED,     9'd2, STATUS_OK},
        '{ACTION_RELEASE,  9'd0,   FIXED,     9'd0, STATUS_NOT_IN_USE},
        '{ACTION_RELEASE,  9'd511, FIXED,     9'd0, STATUS_NOT_IN_USE},
        '{ACTION_RELEASE,  9'd256, FIXED,     9'd0, STATUS_NOT_IN_USE},
        '{ACTION_RELEASE,  9'd257, FIXED,     9'd0, STATUS_NOT_IN_USE},
        '{ACTION_RELEASE,  9'd3,   FIXED,     9'd0, STATUS_NOT_IN_USE},
        '{ACTION_RELEASE,  9'd1,   FIXED,     9'd0, STATUS_OK},
        '{ACTION_RELEASE,  9'd1,   FIXED,     9'd0, STATUS_NOT_IN_USE},
        '{ACTION_RELEASE,  9'd2,   FIXED,     9'd0, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd0,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd255, PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd0,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_RELEASE,  9'd3,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_RELEASE,  9'd1,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd0,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd0,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd0,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_RELEASE,  9'd2,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_RELEASE,  9'd4,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_RELEASE,  9'd2,   PREDICTED, 9'd0, STATUS_OK},
        '{ACTION_ALLOCATE, 9'd0,   PREDICTED, 9'd0, STATUS_OK}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int              fresh_next;
    id_t             recycled_ids [$];
    bit [ID_COUNT:0] id_held;
    reply_t          expected_replies [$];
    int              error_count;
    int              burst_left;
    int              grant_count;
    int              exhausted_count;
    int              free_count;
    int              rejected_count;

    listener_id_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    function automatic reply_t predict_reply(input logic action, input id_t release_id);
        reply_t r;
        r.granted_id = '0;
        r.status     = STATUS_OK;
        if (action == ACTION_ALLOCATE)
        begin
            if (recycled_ids.size() > 0)
            begin
                r.granted_id = recycled_ids[0];
                recycled_ids.delete(0);
            end
            else if (fresh_next <= ID_COUNT)
            begin
                r.granted_id = id_t'(fresh_next);
                fresh_next++;
            end
            else
                r.status = STATUS_EXHAUSTED;
            if (r.status == STATUS_OK)
                id_held[r.granted_id] = 1'b1;
        end
        else if (release_id >= 1 && release_id <= ID_COUNT && id_held[release_id])
        begin
            id_held[release_id] = 1'b0;
            recycled_ids.insert(recycled_ids.size(), release_id);
        end
        else
            r.status = STATUS_NOT_IN_USE;
        return r;
    endfunction

    // Mostly an identifier that is currently held, so that releases succeed.
    function automatic id_t choose_release_id();
        int roll;
        int top;
        int k;
        roll = $urandom_range(0, 9);
        top  = (fresh_next - 1 < ID_COUNT) ? fresh_next - 1 : ID_COUNT;
        if (roll < 8 && top >= 1)
        begin
            for (int attempt = 0; attempt < 32; attempt++)
            begin
                k = $urandom_range(1, top);
                if (id_held[k])
                    return id_t'(k);
            end
        end
        if (roll == 8)
            return id_t'($urandom_range(1, ID_COUNT));
        return id_t'($urandom_range(0, 511));
    endfunction

    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic offer(input logic action, input id_t release_id, input logic source,
                         input id_t fixed_id, input status_t fixed_status);
        reply_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, release_id, action};
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_reply(action, release_id);
        if (action == ACTION_ALLOCATE)
        begin
            if (r.status == STATUS_OK)
                grant_count++;
            else
                exhausted_count++;
        end
        else if (r.status == STATUS_OK)
            free_count++;
        else
            rejected_count++;
        if (source == FIXED)
        begin
            r.granted_id = fixed_id;
            r.status     = fixed_status;
        end
        expected_replies.insert(expected_replies.size(), r);
    endtask

    always @(posedge clk)
    begin
        reply_t r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("response transfer with none expected: tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                r = expected_replies[0];
                expected_replies.delete(0);
                if (m_tdata[8:0] !== r.granted_id)
                begin
                    $error("granted_id: expected %0d, actual %0d", r.granted_id, m_tdata[8:0]);
                    error_count++;
                end
                if (m_tdata[10:9] !== r.status)
                begin
                    $error("status: expected %0d, actual %0d", r.status, m_tdata[10:9]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int unsigned cycle_no;
        int          left;
        rx_mode_t    mode;
        logic        ready;
        cycle_no = 0;
        left     = 0;
        mode     = RX_OPEN;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES)
                ready = 1'b0;
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(16, 200);
                end
                left--;
                case (mode)
                    RX_OPEN:     ready = 1'b1;
                    RX_COIN:     ready = 1'($urandom_range(0, 1));
                    RX_PERIODIC: ready = (cycle_no % 4) != 0;
                    default:     ready = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= ready;
        end
    end

    initial
    begin
        int      alloc_pct;
        logic    action;
        id_t     release_id;
        fresh_next      = 1;
        id_held         = '0;
        error_count     = 0;
        burst_left      = 0;
        grant_count     = 0;
        exhausted_count = 0;
        free_count      = 0;
        rejected_count  = 0;
        alloc_pct       = 95;
        @(posedge rst_n);
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            pace();
            offer(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].release_id, DIRECTED_ROWS[i].source,
                  DIRECTED_ROWS[i].granted_id, DIRECTED_ROWS[i].status);
        end

        // The first phase leans hard on allocation so that exhaustion is reached early.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n > 0 && n % PHASE_LEN == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       alloc_pct = 90;
                    1:       alloc_pct = 55;
                    default: alloc_pct = 20;
                endcase
            end
            pace();
            if ($urandom_range(1, 100) <= alloc_pct)
            begin
                action     = ACTION_ALLOCATE;
                release_id = id_t'($urandom_range(0, 511));
            end
            else
            begin
                action     = ACTION_RELEASE;
                release_id = choose_release_id();
            end
            offer(action, release_id, PREDICTED, '0, STATUS_OK);
        end
        s_tvalid <= 1'b0;

        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d grants and %0d refusals for exhaustion,", grant_count,
                 exhausted_count);
        $display("%0d releases and %0d rejected releases, with %0d mismatches.", free_count,
                 rejected_count, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
rtl/lia_pkg.sv
rtl/lia_fifo.sv
rtl/lia_map.sv
rtl/listener_id_allocator.sv
verif/listener_id_allocator_tb.sv
